// ===== rtl/fua_pkg.sv =====
// ----------------------------------------------------------------------------
// fua_pkg: shared types and constants for the H.264 RTP FU-A packetizer
// Field widths, header bit masks, register indexes and the command record
// that travels from the classifier to the output sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package fua_pkg;

   // field widths
   localparam int BYTE_W = 8;
   localparam int LEN_W  = 16;
   localparam int FS_W   = 12;
   localparam int TSS_W  = 17;
   localparam int SEQ_W  = 16;
   localparam int TS_W   = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 17;

   // default largest NAL length taken from the stream
   localparam int DEF_MAX_NAL_BYTES = 65535;

   // command queue depth
   localparam int CMD_DEPTH = 4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FRAGMENT_SIZE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMESTAMP_STEP = 2'd1;

   // register reset values
   localparam logic [FS_W-1:0]  FRAG_SIZE_RESET = 12'd1400;
   localparam logic [TSS_W-1:0] TS_STEP_RESET   = 17'd3600;

   // NAL / FU-A header bits
   localparam logic [BYTE_W-1:0] NRI_MASK  = 8'h60;
   localparam logic [BYTE_W-1:0] TYPE_MASK = 8'h1F;
   localparam logic [BYTE_W-1:0] FU_A_TYPE = 8'd28;
   localparam logic [BYTE_W-1:0] FU_START  = 8'h80;
   localparam logic [BYTE_W-1:0] FU_END    = 8'h40;
   localparam logic [4:0]        NAL_TYPE_SPS = 5'd7;
   localparam logic [4:0]        NAL_TYPE_PPS = 5'd8;

   // one classified NAL byte, expanded into one or three results
   typedef struct packed {
      logic [BYTE_W-1:0] data;        // the NAL byte itself
      logic [BYTE_W-1:0] fu_ind;      // FU indicator
      logic [BYTE_W-1:0] fu_hdr;      // FU header
      logic              frag_open;   // indicator and header precede the byte
      logic              data_first;  // packet_first on the byte
      logic              data_last;   // packet_last on the byte
      logic [SEQ_W-1:0]  seq;
      logic [TS_W-1:0]   ts;
   } cmd_type;

endpackage

`default_nettype wire

// ===== rtl/fua_front.sv =====
// ----------------------------------------------------------------------------
// fua_front: NAL byte classifier
// Tracks position in the NAL, fragment fill, sequence number and timestamp,
// and turns each accepted byte, but the header of a fragmented NAL, into one command.
// ----------------------------------------------------------------------------
`default_nettype none

module fua_front #(
   parameter int MAX_NAL_BYTES = fua_pkg::DEF_MAX_NAL_BYTES
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       accept,
   input  wire logic [fua_pkg::BYTE_W-1:0] data_byte,
   input  wire logic [fua_pkg::LEN_W-1:0]  nal_length,
   input  wire logic [fua_pkg::FS_W-1:0]   fragment_size,
   input  wire logic [fua_pkg::TSS_W-1:0]  timestamp_step,
   output logic                            cmd_push,
   output fua_pkg::cmd_type                cmd
);

   localparam int IDX_W = $clog2(MAX_NAL_BYTES + 1);
   localparam int CW    = ((IDX_W > fua_pkg::LEN_W) ? IDX_W : fua_pkg::LEN_W) + 1;
   localparam logic [CW-1:0] MAX_LEN = CW'(MAX_NAL_BYTES);

   logic [IDX_W-1:0]            byte_index_ff, byte_index_in;
   logic [fua_pkg::BYTE_W-1:0]  nal_header_ff, nal_header_in;
   logic [fua_pkg::FS_W-1:0]    fill_ff, fill_in;
   logic [fua_pkg::SEQ_W-1:0]   seq_ff, seq_in;
   logic [fua_pkg::TS_W-1:0]    ts_ff, ts_in;

   logic [CW-1:0]               len_z, len_c, b_ext, fs_ext;
   logic [fua_pkg::FS_W-1:0]    fs;
   logic [fua_pkg::BYTE_W-1:0]  hdr;
   logic                        first_byte, is_last, single, frag_end, fill_close;
   logic                        closes, skip_ts;

   // effective length and fragment size
   always_comb begin
      len_z  = (nal_length == '0) ? CW'(1) : CW'(nal_length);
      len_c  = (len_z > MAX_LEN) ? MAX_LEN : len_z;
      fs     = (fragment_size == '0) ? fua_pkg::FS_W'(1) : fragment_size;
      b_ext  = CW'(byte_index_ff);
      fs_ext = CW'(fs);
   end

   // classification of the current byte
   always_comb begin
      first_byte = (byte_index_ff == '0);
      hdr        = first_byte ? data_byte : nal_header_ff;
      is_last    = (b_ext + CW'(1)) >= len_c;
      single     = len_c <= fs_ext;
      frag_end   = (b_ext + fs_ext) >= len_c;
      fill_close = ({1'b0, fill_ff} + 13'd1) >= {1'b0, fs};
      closes     = single ? is_last : (!first_byte && (is_last || fill_close));
      skip_ts    = single && ((hdr[4:0] == fua_pkg::NAL_TYPE_SPS) ||
                              (hdr[4:0] == fua_pkg::NAL_TYPE_PPS));
   end

   // command record, stamped with the counters before this byte
   always_comb begin
      cmd.data       = data_byte;
      cmd.fu_ind     = (hdr & fua_pkg::NRI_MASK) | fua_pkg::FU_A_TYPE;
      cmd.fu_hdr     = (hdr & fua_pkg::TYPE_MASK)
                     | ((byte_index_ff == IDX_W'(1)) ? fua_pkg::FU_START : '0)
                     | (frag_end ? fua_pkg::FU_END : '0);
      cmd.frag_open  = !single && !first_byte && (fill_ff == '0);
      cmd.data_first = single && first_byte;
      cmd.data_last  = closes;
      cmd.seq        = seq_ff;
      cmd.ts         = ts_ff;
      cmd_push       = accept && (single || !first_byte);
   end

   // state update
   always_comb begin
      byte_index_in = byte_index_ff;
      nal_header_in = nal_header_ff;
      fill_in       = fill_ff;
      seq_in        = seq_ff;
      ts_in         = ts_ff;
      if (accept) begin
         if (first_byte) begin
            nal_header_in = data_byte;
         end
         if (!single && !first_byte) begin
            fill_in = closes ? '0 : fill_ff + fua_pkg::FS_W'(1);
         end
         if (closes) begin
            seq_in = seq_ff + fua_pkg::SEQ_W'(1);
         end
         if (is_last) begin
            if (!skip_ts) begin
               ts_in = ts_ff + fua_pkg::TS_W'(timestamp_step);
            end
            byte_index_in = '0;
            fill_in       = '0;
         end else begin
            byte_index_in = byte_index_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_index_ff <= '0;
         nal_header_ff <= '0;
         fill_ff       <= '0;
         seq_ff        <= '0;
         ts_ff         <= '0;
      end else begin
         byte_index_ff <= byte_index_in;
         nal_header_ff <= nal_header_in;
         fill_ff       <= fill_in;
         seq_ff        <= seq_in;
         ts_ff         <= ts_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/fua_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// fua_cmd_fifo: command queue between classifier and output sequencer
// Small register FIFO; head entry is visible while not empty.
// ----------------------------------------------------------------------------
`default_nettype none

module fua_cmd_fifo (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   input  wire fua_pkg::cmd_type push_cmd,
   output logic            full,
   input  wire logic       pop,
   output fua_pkg::cmd_type head_cmd,
   output logic            empty
);

   localparam int PTR_W = $clog2(fua_pkg::CMD_DEPTH);
   localparam int CNT_W = $clog2(fua_pkg::CMD_DEPTH + 1);

   fua_pkg::cmd_type  entry_ff [fua_pkg::CMD_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign full     = (count_ff == CNT_W'(fua_pkg::CMD_DEPTH));
   assign empty    = (count_ff == '0);
   assign head_cmd = entry_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   // pointer and count update, wrapping at the depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(fua_pkg::CMD_DEPTH - 1)) ? '0
                                                                   : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(fua_pkg::CMD_DEPTH - 1)) ? '0
                                                                   : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage, no reset
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/fua_back.sv =====
// ----------------------------------------------------------------------------
// fua_back: output sequencer
// Expands each command into FU indicator, FU header and payload byte (or
// the byte alone) and holds the current result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module fua_back (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       cmd_empty,
   input  wire fua_pkg::cmd_type           cmd,
   output logic                            cmd_pop,
   output logic                            rsp_empty,
   input  wire logic                       rsp_pop,
   output logic [fua_pkg::BYTE_W-1:0]      rsp_payload_byte,
   output logic                            rsp_packet_first,
   output logic                            rsp_packet_last,
   output logic [fua_pkg::SEQ_W-1:0]       rsp_seq_number,
   output logic [fua_pkg::TS_W-1:0]        rsp_rtp_timestamp,
   output logic                            rsp_last_of_item
);

   // position within the current command
   localparam logic [1:0] SUB_IND  = 2'd0;
   localparam logic [1:0] SUB_FUH  = 2'd1;
   localparam logic [1:0] SUB_DATA = 2'd2;

   logic [1:0]                  sub_ff, sub_in, cur;
   logic                        valid_ff, valid_in;
   logic [fua_pkg::BYTE_W-1:0]  byte_ff, byte_in;
   logic                        first_ff, first_in, last_ff, last_in, loi_ff, loi_in;
   logic [fua_pkg::SEQ_W-1:0]   seq_ff;
   logic [fua_pkg::TS_W-1:0]    ts_ff;
   logic                        step;

   // skip the FU bytes on commands that carry none
   always_comb begin
      cur = (sub_ff == SUB_IND && !cmd.frag_open) ? SUB_DATA : sub_ff;
      step = !cmd_empty && (!valid_ff || rsp_pop);
   end

   // select the result for this step
   always_comb begin
      sub_in   = sub_ff;
      byte_in  = cmd.data;
      first_in = cmd.data_first;
      last_in  = cmd.data_last;
      loi_in   = 1'b1;
      cmd_pop  = 1'b0;
      unique case (cur)
         SUB_IND: begin
            byte_in  = cmd.fu_ind;
            first_in = 1'b1;
            last_in  = 1'b0;
            loi_in   = 1'b0;
            if (step) sub_in = SUB_FUH;
         end
         SUB_FUH: begin
            byte_in  = cmd.fu_hdr;
            first_in = 1'b0;
            last_in  = 1'b0;
            loi_in   = 1'b0;
            if (step) sub_in = SUB_DATA;
         end
         SUB_DATA: begin
            cmd_pop = step;
            if (step) sub_in = SUB_IND;
         end
         default: begin
            if (step) sub_in = SUB_IND;
         end
      endcase
   end

   // output register valid
   always_comb begin
      valid_in = valid_ff;
      if (step) begin
         valid_in = 1'b1;
      end else if (rsp_pop) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sub_ff   <= SUB_IND;
         valid_ff <= 1'b0;
      end else begin
         sub_ff   <= sub_in;
         valid_ff <= valid_in;
      end
   end

   // output payload, no reset
   always_ff @(posedge clock) begin
      if (step) begin
         byte_ff  <= byte_in;
         first_ff <= first_in;
         last_ff  <= last_in;
         loi_ff   <= loi_in;
         seq_ff   <= cmd.seq;
         ts_ff    <= cmd.ts;
      end
   end

   assign rsp_empty         = !valid_ff;
   assign rsp_payload_byte  = byte_ff;
   assign rsp_packet_first  = first_ff;
   assign rsp_packet_last   = last_ff;
   assign rsp_seq_number    = seq_ff;
   assign rsp_rtp_timestamp = ts_ff;
   assign rsp_last_of_item  = loi_ff;

endmodule

`default_nettype wire

// ===== rtl/h264_rtp_fua_packetizer_top.sv =====
// A taken byte's command, if any, is written into the command queue; its first result is
// then registered in the fua_back output register. Throughput: one result per cycle
// while rsp_pop takes them; a NAL byte is taken every cycle while the 4-entry command
// queue has room, else req_full stalls it. A fragment-opening byte gives three results.
// Reset (synchronous, active high) clears position, counters and queues and loads
// fragment_size = 1400 and timestamp_step = 3600.
// ----------------------------------------------------------------------------
// h264_rtp_fua_packetizer_top: H.264 RTP packetizer, single-NAL and FU-A
// Holds the configuration registers and joins classifier, command queue
// and output sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module h264_rtp_fua_packetizer_top #(
   parameter int MAX_NAL_BYTES = fua_pkg::DEF_MAX_NAL_BYTES
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // requests
   input  wire logic                           req_push,
   output logic                                req_full,
   input  wire logic [fua_pkg::BYTE_W-1:0]     req_data_byte,
   input  wire logic [fua_pkg::LEN_W-1:0]      req_nal_length,
   // results
   output logic                                rsp_empty,
   input  wire logic                           rsp_pop,
   output logic [fua_pkg::BYTE_W-1:0]          rsp_payload_byte,
   output logic                                rsp_packet_first,
   output logic                                rsp_packet_last,
   output logic [fua_pkg::SEQ_W-1:0]           rsp_seq_number,
   output logic [fua_pkg::TS_W-1:0]            rsp_rtp_timestamp,
   output logic                                rsp_last_of_item,
   // configuration
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [fua_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [fua_pkg::CSR_DATA_W-1:0] csr_data
);

   logic [fua_pkg::FS_W-1:0]  frag_size_ff, frag_size_in;
   logic [fua_pkg::TSS_W-1:0] ts_step_ff, ts_step_in;
   logic                      req_accept, cmd_push, cmd_pop, cmd_empty;
   fua_pkg::cmd_type          push_cmd, head_cmd;

   // configuration registers
   assign csr_ready = 1'b1;

   always_comb begin
      frag_size_in = frag_size_ff;
      ts_step_in   = ts_step_ff;
      if (csr_valid) begin
         if (csr_index == fua_pkg::CSR_FRAGMENT_SIZE) begin
            frag_size_in = csr_data[fua_pkg::FS_W-1:0];
         end else if (csr_index == fua_pkg::CSR_TIMESTAMP_STEP) begin
            ts_step_in = csr_data[fua_pkg::TSS_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frag_size_ff <= fua_pkg::FRAG_SIZE_RESET;
         ts_step_ff   <= fua_pkg::TS_STEP_RESET;
      end else begin
         frag_size_ff <= frag_size_in;
         ts_step_ff   <= ts_step_in;
      end
   end

   assign req_accept = req_push && !req_full;

   fua_front #(
      .MAX_NAL_BYTES (MAX_NAL_BYTES)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .accept         (req_accept),
      .data_byte      (req_data_byte),
      .nal_length     (req_nal_length),
      .fragment_size  (frag_size_ff),
      .timestamp_step (ts_step_ff),
      .cmd_push       (cmd_push),
      .cmd            (push_cmd)
   );

   fua_cmd_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (cmd_push),
      .push_cmd (push_cmd),
      .full     (req_full),
      .pop      (cmd_pop),
      .head_cmd (head_cmd),
      .empty    (cmd_empty)
   );

   fua_back u_back (
      .clock             (clock),
      .reset             (reset),
      .cmd_empty         (cmd_empty),
      .cmd               (head_cmd),
      .cmd_pop           (cmd_pop),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_payload_byte  (rsp_payload_byte),
      .rsp_packet_first  (rsp_packet_first),
      .rsp_packet_last   (rsp_packet_last),
      .rsp_seq_number    (rsp_seq_number),
      .rsp_rtp_timestamp (rsp_rtp_timestamp),
      .rsp_last_of_item  (rsp_last_of_item)
   );

endmodule

`default_nettype wire

// ===== rtl/fua_checker.sv =====
// ----------------------------------------------------------------------------
// fua_checker: port-level checks for the FU-A packetizer
// Watches the top-level ports and flags framing and handshake slips.
// ----------------------------------------------------------------------------
`default_nettype none

module fua_checker (
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       req_full,
   input wire logic                       rsp_empty,
   input wire logic                       rsp_pop,
   input wire logic [fua_pkg::BYTE_W-1:0] rsp_payload_byte,
   input wire logic                       rsp_packet_first,
   input wire logic                       rsp_packet_last,
   input wire logic [fua_pkg::SEQ_W-1:0]  rsp_seq_number,
   input wire logic                       rsp_last_of_item
);

   // reset drains both sides
   a_reset_clears: assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("queues not empty after reset");

   // a waiting result holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=>
         (!rsp_empty && $stable(rsp_payload_byte) && $stable(rsp_seq_number)))
      else $error("result changed while stalled");

   // an FU indicator never closes a packet
   a_ind_not_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_packet_first && !rsp_last_of_item) |-> !rsp_packet_last)
      else $error("FU indicator marked as packet end");

   // FU header follows the indicator at once, in the same packet
   a_hdr_follows: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_pop && rsp_packet_first && !rsp_last_of_item) |=>
         (!rsp_empty && !rsp_packet_first && !rsp_packet_last && !rsp_last_of_item &&
          rsp_seq_number == $past(rsp_seq_number)))
      else $error("FU header missing after indicator");

endmodule

bind h264_rtp_fua_packetizer_top fua_checker u_fua_checker (
   .clock            (clock),
   .reset            (reset),
   .req_full         (req_full),
   .rsp_empty        (rsp_empty),
   .rsp_pop          (rsp_pop),
   .rsp_payload_byte (rsp_payload_byte),
   .rsp_packet_first (rsp_packet_first),
   .rsp_packet_last  (rsp_packet_last),
   .rsp_seq_number   (rsp_seq_number),
   .rsp_last_of_item (rsp_last_of_item)
);

`default_nettype wire
